// ===== design/bit_language_lexer_macros.svh =====
// assertion macros for the bit language lexer
`ifndef BIT_LANGUAGE_LEXER_MACROS_SVH
`define BIT_LANGUAGE_LEXER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge outside reset
`define BLX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bit_language_lexer: same-cycle check failed");

// next-cycle implication
`define BLX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bit_language_lexer: next-cycle check failed");

`else

`define BLX_ASSERT_IMPL(lbl, ante, cons)
`define BLX_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/blx_pkg.sv =====
// shared types, character codes and helper functions for the bit language lexer
`default_nettype none

package blx_pkg;

  localparam int POS_BITS = 16;

  typedef logic [POS_BITS-1:0] pos_t;

  // request kinds; anything else counts as a read error
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_P_UP  = 8'h50;
  localparam logic [7:0] CH_R_UP  = 8'h52;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_P_LO  = 8'h70;
  localparam logic [7:0] CH_R_LO  = 8'h72;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic [7:0] VALUE_NONE = 8'hFF;

  // identifier limit is 255: accum above 25, or 25 followed by a digit above 5, overflows
  localparam logic [7:0] IDENT_LIMIT_TENS = 8'd25;
  localparam logic [3:0] IDENT_LIMIT_ONES = 4'd5;
  localparam logic [7:0] DECIMAL_BASE     = 8'd10;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_IDENT   = 2'd2,
    MODE_STAR    = 2'd3
  } lex_mode_t;

  typedef enum logic [3:0] {
    TOK_EOF      = 4'd0,
    TOK_READERR  = 4'd1,
    TOK_UNKNOWN  = 4'd2,
    TOK_HIGH     = 4'd3,
    TOK_LOW      = 4'd4,
    TOK_OR       = 4'd5,
    TOK_AND      = 4'd6,
    TOK_XOR      = 4'd7,
    TOK_NOT      = 4'd8,
    TOK_FEED     = 4'd9,
    TOK_SHOW     = 4'd10,
    TOK_RSTLHS   = 4'd11,
    TOK_READ     = 4'd12,
    TOK_REGPRINT = 4'd13,
    TOK_REGREAD  = 4'd14,
    TOK_IDENT    = 4'd15
  } token_type_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_READ      = 3'd1,
    ERR_UNKNOWN   = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_NO_NUMBER = 3'd4
  } err_t;

  typedef struct packed {
    lex_mode_t  mode;
    logic [7:0] ident_accum;
    logic       digit_seen;
    pos_t       cur_line;
    pos_t       cur_column;
    pos_t       start_line;
    pos_t       start_column;
    err_t       sticky;
  } lex_state_t;

  typedef struct packed {
    token_type_t ttype;
    logic [7:0]  value;
    pos_t        line;
    pos_t        column;
    err_t        status;
    logic        last;
  } token_t;

  typedef struct packed {
    token_t     tok0;
    token_t     tok1;
    logic [1:0] count;
  } step_out_t;

  function automatic pos_t sat_inc(pos_t v);
    return (v == {POS_BITS{1'b1}}) ? v : v + pos_t'(1);
  endfunction

  // single-character operator table
  function automatic token_type_t char_token(logic [7:0] c);
    token_type_t tt;
    unique case (c)
      CH_ONE:          tt = TOK_HIGH;
      CH_ZERO:         tt = TOK_LOW;
      CH_BAR:          tt = TOK_OR;
      CH_AMP:          tt = TOK_AND;
      CH_CARET:        tt = TOK_XOR;
      CH_TILDE,
      CH_BANG:         tt = TOK_NOT;
      CH_GT:           tt = TOK_FEED;
      CH_LT:           tt = TOK_SHOW;
      CH_DOT:          tt = TOK_RSTLHS;
      CH_QUEST:        tt = TOK_READ;
      default:         tt = TOK_UNKNOWN;
    endcase
    return tt;
  endfunction

  function automatic token_t make_token(token_type_t tt, logic [7:0] value, pos_t line,
                                        pos_t column, err_t status);
    token_t t;
    t.ttype  = tt;
    t.value  = value;
    t.line   = line;
    t.column = column;
    t.status = status;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== design/blx_step.sv =====
// combinational lexer step: next state and up to two tokens for one request
`default_nettype none

module blx_step (
  input  logic [1:0]            kind,
  input  logic [7:0]            byte_value,
  input  blx_pkg::lex_state_t   cur,
  output blx_pkg::lex_state_t   nxt,
  output blx_pkg::step_out_t    res
);

  typedef struct packed {
    blx_pkg::lex_state_t st;
    logic                emit;
    blx_pkg::token_t     tok;
  } norm_t;

  // normal-mode handling of one character
  function automatic norm_t lex_normal(blx_pkg::lex_state_t s, logic [7:0] c);
    norm_t                r;
    blx_pkg::token_type_t tt;
    r.st   = s;
    r.emit = 1'b0;
    r.tok  = '0;
    tt     = blx_pkg::char_token(c);
    if (c == blx_pkg::CH_SPACE || c == blx_pkg::CH_TAB || c == blx_pkg::CH_CR) begin
      r.st.cur_column = blx_pkg::sat_inc(s.cur_column);
    end else if (c == blx_pkg::CH_LF) begin
      r.st.cur_line   = blx_pkg::sat_inc(s.cur_line);
      r.st.cur_column = blx_pkg::pos_t'(1);
    end else if (c == blx_pkg::CH_SEMI) begin
      r.st.cur_column = blx_pkg::sat_inc(s.cur_column);
      r.st.mode       = blx_pkg::MODE_COMMENT;
    end else if (c == blx_pkg::CH_STAR || c == blx_pkg::CH_X) begin
      r.st.start_line   = s.cur_line;
      r.st.start_column = s.cur_column;
      r.st.cur_column   = blx_pkg::sat_inc(s.cur_column);
      if (c == blx_pkg::CH_X) begin
        r.st.ident_accum = 8'd0;
        r.st.digit_seen  = 1'b0;
        r.st.mode        = blx_pkg::MODE_IDENT;
      end else begin
        r.st.mode = blx_pkg::MODE_STAR;
      end
    end else begin
      if (tt == blx_pkg::TOK_UNKNOWN) begin
        r.st.sticky = blx_pkg::ERR_UNKNOWN;
      end
      r.tok           = blx_pkg::make_token(tt, c, s.cur_line, s.cur_column, r.st.sticky);
      r.emit          = 1'b1;
      r.st.cur_column = blx_pkg::sat_inc(s.cur_column);
    end
    return r;
  endfunction

  logic                is_digit;
  logic                is_p;
  logic                is_r;
  logic [7:0]          digit_diff;
  logic [3:0]          digit;
  logic                overflow;
  logic [7:0]          accum_next;
  norm_t               nr;
  blx_pkg::lex_state_t st;
  blx_pkg::token_t     t0;
  blx_pkg::token_t     t1;
  logic                e0;
  logic                e1;

  assign is_digit   = (byte_value >= blx_pkg::CH_ZERO) && (byte_value <= blx_pkg::CH_NINE);
  assign is_p       = (byte_value == blx_pkg::CH_P_LO) || (byte_value == blx_pkg::CH_P_UP);
  assign is_r       = (byte_value == blx_pkg::CH_R_LO) || (byte_value == blx_pkg::CH_R_UP);
  assign digit_diff = byte_value - blx_pkg::CH_ZERO;
  assign digit      = digit_diff[3:0];
  assign overflow   = (cur.ident_accum > blx_pkg::IDENT_LIMIT_TENS) ||
                      ((cur.ident_accum == blx_pkg::IDENT_LIMIT_TENS) &&
                       (digit > blx_pkg::IDENT_LIMIT_ONES));
  assign accum_next = cur.ident_accum * blx_pkg::DECIMAL_BASE + {4'd0, digit};

  always_comb begin
    st = cur;
    t0 = '0;
    t1 = '0;
    e0 = 1'b0;
    e1 = 1'b0;
    nr = '0;
    unique case (kind)
      blx_pkg::KIND_DATA: begin
        unique case (cur.mode)
          blx_pkg::MODE_COMMENT: begin
            if (byte_value == blx_pkg::CH_LF) begin
              st.cur_line   = blx_pkg::sat_inc(cur.cur_line);
              st.cur_column = blx_pkg::pos_t'(1);
              st.mode       = blx_pkg::MODE_NORMAL;
            end else begin
              st.cur_column = blx_pkg::sat_inc(cur.cur_column);
            end
          end
          blx_pkg::MODE_STAR: begin
            st.mode = blx_pkg::MODE_NORMAL;
            if (is_p || is_r) begin
              t0 = blx_pkg::make_token(is_p ? blx_pkg::TOK_REGPRINT : blx_pkg::TOK_REGREAD,
                                       is_p ? blx_pkg::CH_P_LO : blx_pkg::CH_R_LO,
                                       cur.start_line, cur.start_column, st.sticky);
              e0 = 1'b1;
              st.cur_column = blx_pkg::sat_inc(cur.cur_column);
            end else begin
              t0 = blx_pkg::make_token(blx_pkg::TOK_UNKNOWN, blx_pkg::CH_R_LO,
                                       cur.start_line, cur.start_column, st.sticky);
              e0 = 1'b1;
              nr = lex_normal(st, byte_value);
              st = nr.st;
              t1 = nr.tok;
              e1 = nr.emit;
            end
          end
          blx_pkg::MODE_IDENT: begin
            if (is_digit && !overflow) begin
              st.ident_accum = accum_next;
              st.digit_seen  = 1'b1;
              st.cur_column  = blx_pkg::sat_inc(cur.cur_column);
            end else begin
              st.mode = blx_pkg::MODE_NORMAL;
              if (is_digit) begin
                st.sticky = blx_pkg::ERR_OVERFLOW;
                t0 = blx_pkg::make_token(blx_pkg::TOK_UNKNOWN, blx_pkg::CH_X,
                                         cur.start_line, cur.start_column, st.sticky);
              end else if (cur.digit_seen) begin
                t0 = blx_pkg::make_token(blx_pkg::TOK_IDENT, cur.ident_accum,
                                         cur.start_line, cur.start_column, st.sticky);
              end else begin
                st.sticky = blx_pkg::ERR_NO_NUMBER;
                t0 = blx_pkg::make_token(blx_pkg::TOK_UNKNOWN, blx_pkg::CH_X,
                                         cur.start_line, cur.start_column, st.sticky);
              end
              e0 = 1'b1;
              nr = lex_normal(st, byte_value);
              st = nr.st;
              t1 = nr.tok;
              e1 = nr.emit;
            end
          end
          blx_pkg::MODE_NORMAL: begin
            nr = lex_normal(st, byte_value);
            st = nr.st;
            t0 = nr.tok;
            e0 = nr.emit;
          end
        endcase
      end
      blx_pkg::KIND_END: begin
        if (cur.mode == blx_pkg::MODE_STAR) begin
          t0 = blx_pkg::make_token(blx_pkg::TOK_UNKNOWN, blx_pkg::CH_R_LO,
                                   cur.start_line, cur.start_column, st.sticky);
          e0 = 1'b1;
        end else if (cur.mode == blx_pkg::MODE_IDENT) begin
          if (cur.digit_seen) begin
            t0 = blx_pkg::make_token(blx_pkg::TOK_IDENT, cur.ident_accum,
                                     cur.start_line, cur.start_column, st.sticky);
          end else begin
            st.sticky = blx_pkg::ERR_NO_NUMBER;
            t0 = blx_pkg::make_token(blx_pkg::TOK_UNKNOWN, blx_pkg::CH_X,
                                     cur.start_line, cur.start_column, st.sticky);
          end
          e0 = 1'b1;
        end
        st.mode = blx_pkg::MODE_NORMAL;
        if (e0) begin
          t1 = blx_pkg::make_token(blx_pkg::TOK_EOF, blx_pkg::VALUE_NONE,
                                   cur.cur_line, cur.cur_column, st.sticky);
          e1 = 1'b1;
        end else begin
          t0 = blx_pkg::make_token(blx_pkg::TOK_EOF, blx_pkg::VALUE_NONE,
                                   cur.cur_line, cur.cur_column, st.sticky);
          e0 = 1'b1;
        end
      end
      default: begin
        // read error
        if (cur.mode == blx_pkg::MODE_IDENT) begin
          t0 = blx_pkg::make_token(blx_pkg::TOK_READERR, blx_pkg::VALUE_NONE,
                                   cur.cur_line, cur.cur_column, st.sticky);
          e0 = 1'b1;
        end else if (cur.mode == blx_pkg::MODE_STAR) begin
          t0 = blx_pkg::make_token(blx_pkg::TOK_UNKNOWN, blx_pkg::CH_R_LO,
                                   cur.start_line, cur.start_column, st.sticky);
          e0 = 1'b1;
          st.sticky = blx_pkg::ERR_READ;
          t1 = blx_pkg::make_token(blx_pkg::TOK_READERR, blx_pkg::VALUE_NONE,
                                   cur.cur_line, cur.cur_column, st.sticky);
          e1 = 1'b1;
        end else begin
          st.sticky = blx_pkg::ERR_READ;
          t0 = blx_pkg::make_token(blx_pkg::TOK_READERR, blx_pkg::VALUE_NONE,
                                   cur.cur_line, cur.cur_column, st.sticky);
          e0 = 1'b1;
        end
        st.mode = blx_pkg::MODE_NORMAL;
      end
    endcase
    if (e1) begin
      t1.last = 1'b1;
    end else if (e0) begin
      t0.last = 1'b1;
    end
    nxt       = st;
    res.tok0  = t0;
    res.tok1  = t1;
    res.count = {1'b0, e0} + {1'b0, e1};
  end

endmodule

`default_nettype wire

// ===== design/blx_outq.sv =====
// two-entry token queue between the lexer step and the output channel
`default_nettype none

module blx_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  blx_pkg::step_out_t push_data,
  input  logic               out_stall,
  output logic               out_valid,
  output blx_pkg::token_t    head,
  output logic [1:0]         free_slots
);

  logic [1:0]      count;
  logic [1:0]      count_next;
  logic [1:0]      kept;
  logic            pop;
  blx_pkg::token_t q0;
  blx_pkg::token_t q1;
  blx_pkg::token_t q0_next;
  blx_pkg::token_t q1_next;
  blx_pkg::token_t base0;

  assign out_valid  = (count != 2'd0);
  assign head       = q0;
  assign pop        = out_valid && !out_stall;
  assign kept       = count - {1'b0, pop};
  assign free_slots = 2'd2 - kept;
  assign base0      = pop ? q1 : q0;

  always_comb begin
    count_next = kept + (push ? push_data.count : 2'd0);
    unique case (kept)
      2'd0: begin
        q0_next = push_data.tok0;
        q1_next = push_data.tok1;
      end
      2'd1: begin
        q0_next = base0;
        q1_next = push_data.tok0;
      end
      default: begin
        q0_next = base0;
        q1_next = q1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

endmodule

`default_nettype wire

// ===== design/bit_language_lexer.sv =====
// top level of the bit language lexer: input register, lexer state and token queue
`default_nettype none

`include "bit_language_lexer_macros.svh"

// Byte-stream lexer for a small bit-logic language. One request (a source byte, end of
// input or a read error) enters per cycle while in_stall is low and is lexed in a single
// pass from the input register into the lexer state and a two-entry token queue;
// back-to-back requests are taken at one per cycle unless stalled. A request produces
// zero, one or two tokens and leaves the input register only when its tokens fit in the
// queue, so a two-token request that finds a token left in the queue after the current
// output beat waits until that token leaves, longer while the output stalls. The lexer
// state updates when the request leaves the input register; a token passes through the
// input register and the token queue before it is valid on the output. last_of_run marks
// the final token caused by a request. Line and column count from 1 and saturate.
module bit_language_lexer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic [7:0]                byte_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                token_type,
  output logic [7:0]                token_value,
  output logic [blx_pkg::POS_BITS-1:0] token_line,
  output logic [blx_pkg::POS_BITS-1:0] token_column,
  output logic [2:0]                error_status,
  output logic                      last_of_run
);

  logic                in_full;
  logic [1:0]          kind_r;
  logic [7:0]          byte_r;
  logic                accept_in;
  logic                proceed;
  logic [1:0]          free_slots;
  blx_pkg::lex_state_t state;
  blx_pkg::lex_state_t state_next;
  blx_pkg::step_out_t  step_res;
  blx_pkg::token_t     head;

  assign proceed   = in_full && (step_res.count <= free_slots);
  assign in_stall  = in_full && !proceed;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept_in) begin
      in_full <= 1'b1;
    end else if (proceed) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      kind_r <= kind;
      byte_r <= byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode         <= blx_pkg::MODE_NORMAL;
      state.ident_accum  <= 8'd0;
      state.digit_seen   <= 1'b0;
      state.cur_line     <= blx_pkg::pos_t'(1);
      state.cur_column   <= blx_pkg::pos_t'(1);
      state.start_line   <= blx_pkg::pos_t'(1);
      state.start_column <= blx_pkg::pos_t'(1);
      state.sticky       <= blx_pkg::ERR_NONE;
    end else if (proceed) begin
      state <= state_next;
    end
  end

  blx_step u_step (
    .kind       (kind_r),
    .byte_value (byte_r),
    .cur        (state),
    .nxt        (state_next),
    .res        (step_res)
  );

  blx_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (proceed),
    .push_data  (step_res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .head       (head),
    .free_slots (free_slots)
  );

  assign token_type   = head.ttype;
  assign token_value  = head.value;
  assign token_line   = head.line;
  assign token_column = head.column;
  assign error_status = head.status;
  assign last_of_run  = head.last;

  `BLX_ASSERT_IMPL(a_free_range, 1'b1, free_slots <= 2'd2)
  `BLX_ASSERT_IMPL(a_drain_when_empty, in_full && (free_slots == 2'd2), proceed)
  `BLX_ASSERT_IMPL(a_pos_nonzero, out_valid, (token_line != '0) && (token_column != '0))
  `BLX_ASSERT_NEXT(a_hold_request, in_full && !proceed, in_full)

endmodule

`default_nettype wire
